// ----- src/pemq_pkg.sv -----
// Package for the priority evicting message queue.
// Holds widths, reset values, result kinds, register indexes and level bands.
// No dependencies.
package pemq_pkg;

    localparam int unsigned QueueDepth  = 64;
    localparam int unsigned PayloadBits = 32;
    localparam int unsigned MaxBatch    = 64;
    localparam int unsigned NumLevels   = 6;

    localparam int unsigned LevelW = 3;
    localparam int unsigned KindW  = 2;
    localparam int unsigned CountW = 32;
    localparam int unsigned CfgW   = 7;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned LimitW = 7;

    localparam logic [KindW-1:0] KindStatus = 2'd0;
    localparam logic [KindW-1:0] KindEntry  = 2'd1;
    localparam logic [KindW-1:0] KindEmpty  = 2'd2;

    localparam logic [IdxW-1:0] RegMinLevel   = 3'd0;
    localparam logic [IdxW-1:0] RegQueueLimit = 3'd1;
    localparam logic [IdxW-1:0] RegDropLow    = 3'd2;
    localparam logic [IdxW-1:0] RegBatchSize  = 3'd3;
    localparam logic [IdxW-1:0] RegPanicMode  = 3'd4;

    localparam logic [LevelW-1:0] LevelDebug = 3'd1;
    localparam logic [LevelW-1:0] LevelInfo  = 3'd2;
    localparam logic [LevelW-1:0] LevelWarn  = 3'd3;
    localparam logic [LevelW-1:0] LevelFatal = 3'd5;

    localparam logic [LimitW-1:0] ResetQueueLimit = 7'd64;
    localparam logic [LimitW-1:0] ResetBatchSize  = 7'd64;

    // Control from the sequencer to every cell in the chain.
    typedef struct packed {
        logic       pop;        // whole chain shifts toward the head
        logic       evict;      // cells at or past the victim shift down
        logic       append;     // cell at the tail position loads the push
    } t_chain_ctl;

    // Eviction band of a level: 3 = trace/debug, 2 = info, 1 = warn, 0 = none.
    function automatic logic [1:0] band_of(input logic [LevelW-1:0] lvl);
        logic [1:0] b;
        begin
            if (lvl <= LevelDebug) begin
                b = 2'd3;
            end else if (lvl == LevelInfo) begin
                b = 2'd2;
            end else if (lvl == LevelWarn) begin
                b = 2'd1;
            end else begin
                b = 2'd0;
            end
            return b;
        end
    endfunction

endpackage

// ----- src/priority_evicting_message_queue.sv -----
// Top level of the priority evicting message queue.
// Chain of pemq_cell storage cells plus the command sequencer.
// Depends on pemq_pkg and pemq_cell.
//
//  channel  direction  handshake           payload
//  in       input      i_valid / o_stall   command, level, payload
//  out      output     o_valid / i_stall   kind ... last
//  cfg      input      i_cfg_we            i_cfg_index, i_cfg_data
//
// In a push, victim search, gap closing and append happen together in the cell
// chain, and its result beat leaves on the next cycle unless its level is fatal.
// A drain or fatal flush emits one entry per cycle while the output is not stalled, one chain shift each.
// Input is stalled while an item is in work or any result beat is held.
// Reset clears fill, drop counters and registers; cell contents are left.
module priority_evicting_message_queue #(
    parameter int unsigned QUEUE_DEPTH  = pemq_pkg::QueueDepth,
    parameter int unsigned PAYLOAD_BITS = pemq_pkg::PayloadBits,
    parameter int unsigned MAX_BATCH    = pemq_pkg::MaxBatch
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [pemq_pkg::LevelW-1:0]   i_level,
    input  logic [PAYLOAD_BITS-1:0]       i_payload,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pemq_pkg::KindW-1:0]    o_kind,
    output logic [pemq_pkg::LevelW-1:0]   o_out_level,
    output logic [PAYLOAD_BITS-1:0]       o_out_payload,
    output logic                          o_enqueued,
    output logic                          o_dropped,
    output logic                          o_evicted,
    output logic [pemq_pkg::LevelW-1:0]   o_evicted_level,
    output logic [pemq_pkg::CountW-1:0]   o_total_drops,
    output logic [pemq_pkg::CountW-1:0]   o_level_drops,
    output logic [pemq_pkg::LimitW-1:0]   o_fill,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [pemq_pkg::IdxW-1:0]     i_cfg_index,
    input  logic [pemq_pkg::CfgW-1:0]     i_cfg_data
);

    localparam int unsigned FillW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BatchW = $clog2(MAX_BATCH + 1);
    localparam int unsigned LW     = pemq_pkg::LevelW;
    localparam int unsigned CW     = pemq_pkg::CountW;
    localparam logic [CW-1:0] CountMax = '1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FLUSH = 3'b010,
        S_OUT   = 3'b100
    } t_state;

    // configuration
    logic [LW-1:0]                  r_min_level;
    logic [pemq_pkg::LimitW-1:0]    r_queue_limit;
    logic                           r_drop_low;
    logic [pemq_pkg::LimitW-1:0]    r_batch_size;
    logic                           r_panic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level   <= '0;
            r_queue_limit <= pemq_pkg::ResetQueueLimit;
            r_drop_low    <= 1'b0;
            r_batch_size  <= pemq_pkg::ResetBatchSize;
            r_panic       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pemq_pkg::RegMinLevel:   r_min_level   <= i_cfg_data[LW-1:0];
                pemq_pkg::RegQueueLimit: r_queue_limit <= i_cfg_data;
                pemq_pkg::RegDropLow:    r_drop_low    <= i_cfg_data[0];
                pemq_pkg::RegBatchSize:  r_batch_size  <= i_cfg_data;
                pemq_pkg::RegPanicMode:  r_panic       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // cell chain
    logic [LW-1:0]            w_level   [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0]  w_payload [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   w_past_victim;
    logic [QUEUE_DEPTH-1:0]   w_at_tail;
    pemq_pkg::t_chain_ctl     w_ctl;

    logic [FillW-1:0]         r_fill, n_fill;
    logic [FillW-1:0]         w_tail_pos;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [LW-1:0]           up_level;
        logic [PAYLOAD_BITS-1:0] up_payload;
        if (g == QUEUE_DEPTH - 1) begin : g_top
            assign up_level   = w_level[g];
            assign up_payload = w_payload[g];
        end else begin : g_mid
            assign up_level   = w_level[g+1];
            assign up_payload = w_payload[g+1];
        end
        assign w_at_tail[g] = (w_tail_pos == FillW'(g));
        pemq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_at_tail     (w_at_tail[g]),
            .i_past_victim (w_past_victim[g]),
            .i_up_level    (up_level),
            .i_up_payload  (up_payload),
            .i_new_level   (i_level),
            .i_new_payload (i_payload),
            .o_level       (w_level[g]),
            .o_payload     (w_payload[g])
        );
    end

    // Victim search: per cell band, then the newest cell of the highest band.
    logic [QUEUE_DEPTH-1:0] w_in_band [3];
    logic [QUEUE_DEPTH-1:0] w_newest  [3];
    logic [2:0]             w_band_any;
    logic [QUEUE_DEPTH-1:0] w_victim;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_band
        logic [1:0] b;
        assign b = pemq_pkg::band_of(w_level[g]);
        assign w_in_band[0][g] = (FillW'(g) < r_fill) && (b == 2'd3);
        assign w_in_band[1][g] = (FillW'(g) < r_fill) && (b == 2'd2);
        assign w_in_band[2][g] = (FillW'(g) < r_fill) && (b == 2'd1);
    end

    for (genvar k = 0; k < 3; k++) begin : g_newest
        // newest = highest set bit: bit g set and no higher set bit
        logic [QUEUE_DEPTH-1:0] higher;
        for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_bit
            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign higher[g] = 1'b0;
            end else begin : g_rest
                assign higher[g] = higher[g+1] | w_in_band[k][g+1];
            end
            assign w_newest[k][g] = w_in_band[k][g] & ~higher[g];
        end
        assign w_band_any[k] = |w_in_band[k];
    end

    always_comb begin
        if (w_band_any[0]) begin
            w_victim = w_newest[0];
        end else if (w_band_any[1]) begin
            w_victim = w_newest[1];
        end else begin
            w_victim = w_newest[2];
        end
    end

    // cells at or above the victim shift down by one
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_past
        if (g == 0) begin : g_first
            assign w_past_victim[g] = w_victim[g];
        end else begin : g_next
            assign w_past_victim[g] = w_past_victim[g-1] | w_victim[g];
        end
    end

    logic [LW-1:0] w_victim_level;
    always_comb begin
        w_victim_level = '0;
        for (int unsigned j = 0; j < QUEUE_DEPTH; j++) begin
            w_victim_level = w_victim_level | (w_victim[j] ? w_level[j] : '0);
        end
    end

    // sequencer
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_total, n_total;
    logic [CW-1:0]            r_lvl_cnt [pemq_pkg::NumLevels];
    logic [BatchW-1:0]        r_left, n_left;

    logic                     r_valid, n_valid;
    logic [pemq_pkg::KindW-1:0] r_kind, n_kind;
    logic [LW-1:0]            r_olevel, n_olevel;
    logic [PAYLOAD_BITS-1:0]  r_opay, n_opay;
    logic                     r_enq, n_enq, r_drp, n_drp, r_ev, n_ev;
    logic [LW-1:0]            r_evl, n_evl;
    logic [CW-1:0]            r_ld, n_ld;
    logic [FillW-1:0]         r_ofill, n_ofill;
    logic                     r_last, n_last;

    logic                     w_accept, w_out_free;
    logic                     w_bump;
    logic [FillW-1:0]         w_limit;
    logic [BatchW-1:0]        w_batch;
    logic                     w_lvl_ok;
    logic [CW-1:0]            w_cur_ld;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || r_valid;
    assign w_lvl_ok   = (i_level < LW'(pemq_pkg::NumLevels));
    assign w_cur_ld   = w_lvl_ok ? r_lvl_cnt[i_level] : '0;

    always_comb begin
        if (32'(r_queue_limit) > QUEUE_DEPTH) begin
            w_limit = FillW'(QUEUE_DEPTH);
        end else begin
            w_limit = FillW'(r_queue_limit);
        end
        if (32'(r_batch_size) > MAX_BATCH) begin
            w_batch = BatchW'(MAX_BATCH);
        end else begin
            w_batch = BatchW'(r_batch_size);
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_total = r_total;
        n_left  = r_left;
        n_valid = r_valid && i_stall;
        n_kind  = r_kind;   n_olevel = r_olevel; n_opay = r_opay;
        n_enq   = r_enq;    n_drp    = r_drp;    n_ev   = r_ev;
        n_evl   = r_evl;    n_ld     = r_ld;     n_ofill = r_ofill;
        n_last  = r_last;
        w_ctl      = '0;
        w_tail_pos = r_fill;
        w_bump     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid  = 1'b1;
                    n_olevel = i_level;
                    n_opay   = i_payload;
                    n_enq = 1'b0; n_drp = 1'b0; n_ev = 1'b0; n_evl = '0;
                    n_ld  = w_cur_ld;
                    n_ofill = r_fill;
                    n_last  = 1'b1;
                    n_kind  = pemq_pkg::KindStatus;
                    if (i_command) begin
                        n_ld = '0;
                        n_olevel = '0;
                        n_opay   = '0;
                        if (r_fill == '0) begin
                            n_kind = pemq_pkg::KindEmpty;
                        end else begin
                            n_valid = 1'b0;
                            n_left  = w_batch;
                            n_state = S_FLUSH;
                        end
                    end else if (!w_lvl_ok || i_level < r_min_level) begin
                        n_kind = pemq_pkg::KindStatus;
                    end else if (r_panic) begin
                        n_kind = pemq_pkg::KindEntry;
                    end else begin
                        if (r_fill < w_limit) begin
                            w_ctl.append = 1'b1;
                            n_fill = r_fill + 1'b1;
                            n_enq  = 1'b1;
                        end else begin
                            n_drp  = 1'b1;
                            w_bump = 1'b1;
                            if (r_drop_low && (|w_band_any)) begin
                                w_ctl.evict  = 1'b1;
                                w_ctl.append = 1'b1;
                                w_tail_pos   = r_fill - 1'b1;
                                n_ev  = 1'b1;
                                n_evl = w_victim_level;
                                n_enq = 1'b1;
                            end
                            if (r_total != CountMax) begin
                                n_total = r_total + 1'b1;
                            end
                            if (w_cur_ld != CountMax) begin
                                n_ld = w_cur_ld + 1'b1;
                            end
                        end
                        n_ofill = n_fill;
                        if (i_level == pemq_pkg::LevelFatal) begin
                            n_valid = 1'b0;
                            n_left  = w_batch;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            // fatal push: decide between flush and status beat
            S_OUT: begin
                if (r_fill == '0 || r_left == '0) begin
                    n_valid = 1'b1;
                    n_kind  = pemq_pkg::KindStatus;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_fill == '0 || r_left == '0) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_ctl.pop = 1'b1;
                    n_valid   = 1'b1;
                    n_kind    = pemq_pkg::KindEntry;
                    n_olevel  = w_level[0];
                    n_opay    = w_payload[0];
                    n_fill    = r_fill - 1'b1;
                    n_ofill   = r_fill - 1'b1;
                    n_left    = r_left - 1'b1;
                    n_last    = (r_fill == FillW'(1)) || (r_left == BatchW'(1));
                    if (n_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
            r_left  <= '0;
            for (int unsigned j = 0; j < pemq_pkg::NumLevels; j++) begin
                r_lvl_cnt[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_valid <= n_valid;
            r_left  <= n_left;
            if (w_bump && r_lvl_cnt[i_level] != CountMax) begin
                r_lvl_cnt[i_level] <= r_lvl_cnt[i_level] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;   r_olevel <= n_olevel; r_opay <= n_opay;
        r_enq    <= n_enq;    r_drp    <= n_drp;    r_ev   <= n_ev;
        r_evl    <= n_evl;    r_ld     <= n_ld;     r_ofill <= n_ofill;
        r_last   <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_out_level     = r_olevel;
    assign o_out_payload   = r_opay;
    assign o_enqueued      = r_enq;
    assign o_dropped       = r_drp;
    assign o_evicted       = r_ev;
    assign o_evicted_level = r_evl;
    assign o_level_drops   = r_ld;
    assign o_fill          = pemq_pkg::LimitW'(r_ofill);
    assign o_last          = r_last;
    // total is sampled live: no drop can land while a beat is shown
    assign o_total_drops   = r_total;

endmodule

// ----- src/pemq_cell.sv -----
// One storage cell of the queue chain: a level and a payload.
// Shifts from its upper neighbor on pop or evict, loads the push on append.
// Depends on pemq_pkg.
module pemq_cell #(
    parameter int unsigned PAYLOAD_BITS = pemq_pkg::PayloadBits
) (
    input  logic                          i_clk,
    input  pemq_pkg::t_chain_ctl          i_ctl,
    input  logic                          i_at_tail,
    input  logic                          i_past_victim,
    input  logic [pemq_pkg::LevelW-1:0]   i_up_level,
    input  logic [PAYLOAD_BITS-1:0]       i_up_payload,
    input  logic [pemq_pkg::LevelW-1:0]   i_new_level,
    input  logic [PAYLOAD_BITS-1:0]       i_new_payload,
    output logic [pemq_pkg::LevelW-1:0]   o_level,
    output logic [PAYLOAD_BITS-1:0]       o_payload
);

    logic [pemq_pkg::LevelW-1:0] r_level, n_level;
    logic [PAYLOAD_BITS-1:0]     r_payload, n_payload;

    always_comb begin
        n_level   = r_level;
        n_payload = r_payload;
        if (i_ctl.pop || (i_ctl.evict && i_past_victim)) begin
            n_level   = i_up_level;
            n_payload = i_up_payload;
        end
        if (i_ctl.append && i_at_tail) begin
            n_level   = i_new_level;
            n_payload = i_new_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level   <= n_level;
        r_payload <= n_payload;
    end

    assign o_level   = r_level;
    assign o_payload = r_payload;

endmodule

// ----- src/pemq_checker.sv -----
// Port-level checker for the priority evicting message queue.
// Bound to priority_evicting_message_queue; depends on pemq_pkg.
module pemq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [pemq_pkg::KindW-1:0]  o_kind,
    input logic [pemq_pkg::CountW-1:0] o_total_drops,
    input logic                        o_enqueued,
    input logic                        o_evicted,
    input logic                        o_dropped,
    input logic                        o_last
);

    a_evict_implies_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> o_dropped && o_enqueued)
        else $error("eviction without drop and enqueue");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == pemq_pkg::KindEmpty |-> o_last)
        else $error("empty drain beat not last");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_total_drops >= $past(o_total_drops))
        else $error("total drops decreased");

    a_stall_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_last))
        else $error("stalled beat changed");

endmodule

bind priority_evicting_message_queue pemq_checker u_pemq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_total_drops (o_total_drops),
    .o_enqueued    (o_enqueued),
    .o_evicted     (o_evicted),
    .o_dropped     (o_dropped),
    .o_last        (o_last)
);
